/* sv/lpcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcc_pkg
// Shared types and constants of the point colorizer datapath.
// ----------------------------------------------------------------------------
package lpcc_pkg;

  localparam int CW = 44;   // camera coordinate, 28 fraction bits
  localparam int NW = 67;   // signed projection numerator
  localparam int DW = 51;   // denominator 256 * depth
  localparam int QB = 13;   // quotient bits kept by the divider

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [2:0] REG_ROT0  = 3'd0;
  localparam logic [2:0] REG_ROT1  = 3'd1;
  localparam logic [2:0] REG_ROT2  = 3'd2;
  localparam logic [2:0] REG_TRANS = 3'd3;
  localparam logic [2:0] REG_FOCAL = 3'd4;
  localparam logic [2:0] REG_PRINC = 3'd5;
  localparam logic [2:0] REG_DIMS  = 3'd6;

  typedef struct packed {
    logic [53:0] rot0;
    logic [53:0] rot1;
    logic [53:0] rot2;
    logic [62:0] trans;
    logic [39:0] focal;
    logic [39:0] princ;
    logic [23:0] dims;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [20:0] idx;
    logic [23:0] rgb;
  } side_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [NW-2:0] rem;
    logic [QB-1:0] q;
  } axis_t;

  typedef struct packed {
    logic          front;
    logic [DW-1:0] den;
    axis_t         ax;
    axis_t         ay;
    side_t         side;
  } dstage_t;

endpackage

/* sv/lpcc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcc_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lpcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/lpcc_xform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcc_xform
// Rigid transform of a world point into camera coordinates, three stages.
// ----------------------------------------------------------------------------
module lpcc_xform
  import lpcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  input  side_t                in_side,
  input  logic [71:0]          in_point,
  output logic                 out_valid,
  output side_t                out_side,
  output logic signed [CW-1:0] out_cam [3]
);

  logic [53:0]        rows [3];
  logic signed [23:0] pt_r [3];
  logic signed [41:0] prod_r [3][3];
  logic signed [CW-1:0] cam_r [3];
  logic [2:0]         v_r;
  side_t              s1_r, s2_r, s3_r;

  assign rows[0] = cfg.rot0;
  assign rows[1] = cfg.rot1;
  assign rows[2] = cfg.rot2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_side;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [20:0] tv;
    logic signed [36:0] tsh;
    assign tv  = cfg.trans[21*r +: 21];
    assign tsh = {tv, 16'b0};

    always_ff @(posedge clk) begin
      if (en) begin
        pt_r[r]  <= in_point[24*r +: 24];
        cam_r[r] <= CW'(prod_r[r][0]) + CW'(prod_r[r][1]) + CW'(prod_r[r][2]) + CW'(tsh);
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [17:0] coef;
      assign coef = rows[r][18*c +: 18];
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[r][c] <= coef * pt_r[c];
        end
      end
    end
  end

  assign out_valid = v_r[2];
  assign out_side  = s3_r;
  assign out_cam   = cam_r;

endmodule

/* sv/lpcc_proj.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcc_proj
// Builds the pinhole numerators and the depth denominator, takes magnitudes
// and flags quotients too large for the divider, four stages.
// ----------------------------------------------------------------------------
module lpcc_proj
  import lpcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  input  side_t                in_side,
  input  logic signed [CW-1:0] in_cam [3],
  output logic                 out_valid,
  output dstage_t              out_stage
);

  logic [3:0]          v_r;
  side_t               s1_r, s2_r, s3_r, s4_r;
  logic                f1_r, f2_r, f3_r, f4_r;
  logic [DW-1:0]       den2_r, den3_r, den4_r;
  logic signed [CW-1:0] z1_r;
  logic signed [NW-1:0] num_r [2];
  logic                neg_r [2];
  logic [NW-2:0]       mag_r [2];
  logic                ovf_r [2];
  logic [NW-2:0]       mag4_r [2];
  logic                neg4_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= in_side;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      s4_r   <= s3_r;
      f1_r   <= in_cam[2] > 0;
      f2_r   <= f1_r;
      f3_r   <= f2_r;
      f4_r   <= f3_r;
      z1_r   <= in_cam[2];
      den2_r <= {z1_r[DW-9:0], 8'b0};
      den3_r <= den2_r;
      den4_r <= den3_r;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [20:0] fs;
    logic signed [21:0] cs;
    logic signed [22:0] alo, zlo;
    logic signed [21:0] ahi, zhi;
    logic signed [43:0] p_alo_r, p_zhi_r;
    logic signed [42:0] p_ahi_r;
    logic signed [44:0] p_zlo_r;

    assign fs  = {1'b0, cfg.focal[20*a +: 20]};
    assign cs  = 22'({2'b0, cfg.princ[20*a +: 20]} + 22'd128);
    assign alo = {1'b0, in_cam[a][21:0]};
    assign ahi = in_cam[a][CW-1:22];
    assign zlo = {1'b0, in_cam[2][21:0]};
    assign zhi = in_cam[2][CW-1:22];

    always_ff @(posedge clk) begin
      if (en) begin
        p_alo_r   <= fs * alo;
        p_ahi_r   <= fs * ahi;
        p_zlo_r   <= cs * zlo;
        p_zhi_r   <= cs * zhi;
        num_r[a]  <= (NW'(p_ahi_r) <<< 22) + NW'(p_alo_r)
                   + (NW'(p_zhi_r) <<< 22) + NW'(p_zlo_r);
        neg_r[a]  <= num_r[a][NW-1];
        mag_r[a]  <= num_r[a][NW-1] ? (NW-1)'(-num_r[a]) : (NW-1)'(num_r[a]);
        neg4_r[a] <= neg_r[a];
        mag4_r[a] <= mag_r[a];
        ovf_r[a]  <= mag_r[a] >= ((NW-1)'(den3_r) << QB);
      end
    end
  end

  assign out_valid            = v_r[3];
  assign out_stage.front      = f4_r;
  assign out_stage.den        = den4_r;
  assign out_stage.side       = s4_r;
  assign out_stage.ax.neg     = neg4_r[0];
  assign out_stage.ax.ovf     = ovf_r[0];
  assign out_stage.ax.rem     = mag4_r[0];
  assign out_stage.ax.q       = '0;
  assign out_stage.ay.neg     = neg4_r[1];
  assign out_stage.ay.ovf     = ovf_r[1];
  assign out_stage.ay.rem     = mag4_r[1];
  assign out_stage.ay.q       = '0;

endmodule

/* sv/lpcc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcc_div
// Pipelined restoring divider, one quotient bit per stage for both axes.
// ----------------------------------------------------------------------------
module lpcc_div
  import lpcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  dstage_t in_stage,
  output logic    out_valid,
  output dstage_t out_stage
);

  dstage_t st [QB+1];
  logic    v  [QB+1];

  assign st[0] = in_stage;
  assign v[0]  = in_valid;

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int B = QB - 1 - k;
    logic [NW-2:0] dsh;
    dstage_t       nxt;

    assign dsh = (NW-1)'(st[k].den) << B;

    always_comb begin
      nxt = st[k];
      if (st[k].ax.rem >= dsh) begin
        nxt.ax.rem  = st[k].ax.rem - dsh;
        nxt.ax.q[B] = 1'b1;
      end
      if (st[k].ay.rem >= dsh) begin
        nxt.ay.rem  = st[k].ay.rem - dsh;
        nxt.ay.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign out_valid = v[QB];
  assign out_stage = st[QB];

endmodule

/* sv/lidar_point_camera_colorizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_camera_colorizer
// Pixel store writes and pinhole projection of points with color lookup.
// ----------------------------------------------------------------------------
// The input stream carries two kinds of transaction, chosen by in_tuser.
// A pixel write stores one RGB pixel at its row-major index and returns
// nothing. A projection transaction transforms a world point into the
// camera, divides by depth, rounds to a pixel and returns that pixel's color
// with alpha 255, or all zeros when the point is behind the camera or
// outside the image. Results leave in input order on the out_ stream.
// One transaction is accepted every cycle unless the receiver stalls. A
// projection result passes the three transform stages, four numerator
// stages, thirteen divider stages, the address stage and the registered
// read of the pixel memory. A write passes a delay line alongside them and
// reaches the memory ahead of any later projection's read.
// When the receiver stalls, the whole pipeline holds and in_tready drops.
// Reset clears the pipeline and the configuration registers; the pixel
// memory is not cleared, and a pixel must be written before it is sampled.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata, by the
// user only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module lidar_point_camera_colorizer
  import lpcc_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pixel_index, pixel_blue, pixel_green, pixel_red, point_x, point_y,
  // point_z, zero padding
  input  logic [119:0] in_tdata,
  // operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // blue, green, red, alpha
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [62:0]  cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  cfg_t    cfg_r;
  logic    adv;
  side_t   in_side;
  logic    xf_valid, pj_valid, dv_valid;
  side_t   xf_side;
  logic signed [CW-1:0] cam [3];
  dstage_t pj_stage, dv_stage;

  logic [12:0] w_clamp, h_clamp;
  logic        in_x, in_y;
  logic [25:0] prj_addr;

  logic          a_valid_r, a_op_r, a_wok_r, a_seen_r;
  logic [AW-1:0] a_addr_r;
  logic [23:0]   a_rgb_r;
  logic          out_valid_r, seen_r;
  logic [23:0]   rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROT0:  cfg_r.rot0  <= cfg_wdata[53:0];
        REG_ROT1:  cfg_r.rot1  <= cfg_wdata[53:0];
        REG_ROT2:  cfg_r.rot2  <= cfg_wdata[53:0];
        REG_TRANS: cfg_r.trans <= cfg_wdata;
        REG_FOCAL: cfg_r.focal <= cfg_wdata[39:0];
        REG_PRINC: cfg_r.princ <= cfg_wdata[39:0];
        REG_DIMS:  cfg_r.dims  <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign in_side.op  = in_tuser;
  assign in_side.idx = in_tdata[20:0];
  assign in_side.rgb = in_tdata[44:21];

  lpcc_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid && in_tuser == OP_PROJECT),
    .in_side   (in_side),
    .in_point  (in_tdata[116:45]),
    .out_valid (xf_valid),
    .out_side  (xf_side),
    .out_cam   (cam)
  );

  lpcc_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .cfg       (cfg_r),
    .in_valid  (xf_valid),
    .in_side   (xf_side),
    .in_cam    (cam),
    .out_valid (pj_valid),
    .out_stage (pj_stage)
  );

  lpcc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (pj_valid),
    .in_stage  (pj_stage),
    .out_valid (dv_valid),
    .out_stage (dv_stage)
  );

  // Pixel writes travel the same pipeline so they stay ordered with reads;
  // their valid is carried in the write path below.
  logic [19:0] wv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
    end else if (adv) begin
      wv_r <= {wv_r[18:0], in_tvalid && in_tuser == OP_WRITE};
    end
  end

  assign w_clamp = ({1'b0, cfg_r.dims[11:0]} > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)
                                                                 : {1'b0, cfg_r.dims[11:0]};
  assign h_clamp = ({1'b0, cfg_r.dims[23:12]} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                                  : {1'b0, cfg_r.dims[23:12]};

  assign in_x = !dv_stage.ax.ovf && (!dv_stage.ax.neg || dv_stage.ax.q == '0)
                && dv_stage.ax.q < w_clamp;
  assign in_y = !dv_stage.ay.ovf && (!dv_stage.ay.neg || dv_stage.ay.q == '0)
                && dv_stage.ay.q < h_clamp;
  assign prj_addr = 26'(dv_stage.ay.q * w_clamp) + 26'(dv_stage.ax.q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= dv_valid || wv_r[19];
      out_valid_r <= a_valid_r && a_op_r == OP_PROJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r   <= dv_valid ? OP_PROJECT : OP_WRITE;
      a_seen_r <= dv_stage.front && in_x && in_y;
      a_rgb_r  <= dv_stage.side.rgb;
      a_wok_r  <= 32'(dv_stage.side.idx) < 32'(DEPTH);
      a_addr_r <= dv_valid ? AW'(prj_addr) : AW'(dv_stage.side.idx);
      seen_r   <= a_seen_r;
    end
  end

  lpcc_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (adv && a_valid_r && (a_op_r == OP_PROJECT || a_wok_r)),
    .we    (a_op_r == OP_WRITE),
    .addr  (a_addr_r),
    .wdata (a_rgb_r),
    .rdata (rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = seen_r ? {8'hFF, rdata} : 32'd0;

endmodule
